// ----- src/rss_pkg.sv -----
// rss_pkg: shared types and fixed widths for the running sample statistics block.
// Depends on nothing; every other file in src imports it.
package rss_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int MAG_BITS    = SAMPLE_BITS + 1;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  // input item as it arrives on the port
  typedef struct packed {
    cmd_t                          command;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  // classified item held in the queue between front and back
  typedef struct packed {
    logic                          clear;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [MAG_BITS-1:0]           mag;
  } op_t;

  // result item
  typedef struct packed {
    logic [COUNT_BITS-1:0]         sample_count;
    logic signed [SUM_BITS-1:0]    running_sum;
    logic signed [SAMPLE_BITS-1:0] last_sample;
    logic signed [SAMPLE_BITS-1:0] least_value;
    logic signed [SAMPLE_BITS-1:0] greatest_value;
    logic [SAMPLE_BITS-1:0]        least_magnitude;
    logic [SAMPLE_BITS-1:0]        greatest_magnitude;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          valid_res;
    logic                          full_res;
  } stats_t;

endpackage

// ----- src/rss_front.sv -----
// rss_front: accepts input items, classifies them and queues them for the back end.
// Depends on rss_pkg.
module rss_front #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  rss_pkg::item_t item,
  output logic          q_valid,
  output rss_pkg::op_t  q_op,
  input  logic          q_pop
);
  import rss_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  op_t               mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic [MAG_BITS-1:0] ext;
  op_t               op_in;

  assign item_stall = (fill == FILL_W'(DEPTH));
  assign push       = item_valid && !item_stall;
  assign q_valid    = (fill != '0);
  assign q_op       = mem[rd_ptr];

  // magnitude is one bit wider so the most negative sample fits
  always_comb begin
    ext          = {item.sample[SAMPLE_BITS-1], item.sample};
    op_in.clear  = (item.command == CMD_CLEAR);
    op_in.sample = item.sample;
    op_in.mag    = ext[MAG_BITS-1] ? (~ext + 1'b1) : ext;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/rss_divider.sv -----
// rss_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on rss_pkg.
module rss_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rss_pkg::SUM_BITS-1:0]   dividend,
  input  logic [rss_pkg::COUNT_BITS-1:0] divisor,
  output logic                           done,
  output logic [rss_pkg::SUM_BITS-1:0]   quotient
);
  import rss_pkg::*;

  localparam int STEP_W = $clog2(SUM_BITS);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] dvsr;
  logic [SUM_BITS-1:0]   quot;
  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   rem_diff;
  logic                  fits;

  assign quotient = quot;

  // remainder stays below the divisor, so its top bit is free for the shift-in
  always_comb begin
    rem_shift = {rem[COUNT_BITS-1:0], quot[SUM_BITS-1]};
    rem_diff  = rem_shift - {1'b0, dvsr};
    fits      = (rem_shift >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quot <= dividend;
        dvsr <= divisor;
      end else if (busy) begin
        rem  <= fits ? rem_diff : rem_shift;
        quot <= {quot[SUM_BITS-2:0], fits};
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/rss_engine.sv -----
// rss_engine: back end; updates the statistics, runs the mean division, drives results.
// Depends on rss_pkg and rss_divider.
module rss_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  rss_pkg::op_t    q_op,
  output logic            q_pop,
  output logic            stats_valid,
  input  logic            stats_stall,
  output rss_pkg::stats_t stats
);
  import rss_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_DIVIDE,
    S_WRITE
  } state_t;

  state_t                        state;
  logic [COUNT_BITS-1:0]         count;
  logic signed [SUM_BITS-1:0]    total;
  logic signed [SAMPLE_BITS-1:0] latest;
  logic signed [SAMPLE_BITS-1:0] least;
  logic signed [SAMPLE_BITS-1:0] greatest;
  logic [MAG_BITS-1:0]           mag_least;
  logic [MAG_BITS-1:0]           mag_greatest;
  logic                          full_flag;

  logic [COUNT_BITS-1:0]         count_next;
  logic signed [SUM_BITS-1:0]    total_next;
  logic signed [SAMPLE_BITS-1:0] latest_next;
  logic signed [SAMPLE_BITS-1:0] least_next;
  logic signed [SAMPLE_BITS-1:0] greatest_next;
  logic [MAG_BITS-1:0]           mag_least_next;
  logic [MAG_BITS-1:0]           mag_greatest_next;
  logic                          full_next;

  logic                div_start;
  logic                div_done;
  logic [SUM_BITS-1:0] div_dividend;
  logic [SUM_BITS-1:0] div_quot;
  logic [SUM_BITS-1:0] avg_full;
  logic                out_free;
  stats_t              stats_next;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_LAUNCH);
  assign out_free  = !stats_valid || !stats_stall;

  // statistics update for the item at the head of the queue
  always_comb begin
    count_next        = count;
    total_next        = total;
    latest_next       = latest;
    least_next        = least;
    greatest_next     = greatest;
    mag_least_next    = mag_least;
    mag_greatest_next = mag_greatest;
    full_next         = 1'b0;
    if (q_op.clear) begin
      count_next        = '0;
      total_next        = '0;
      latest_next       = '0;
      least_next        = '0;
      greatest_next     = '0;
      mag_least_next    = '0;
      mag_greatest_next = '0;
    end else if (count == '1) begin
      full_next = 1'b1;
    end else begin
      count_next  = count + 1'b1;
      total_next  = total + {{COUNT_BITS{q_op.sample[SAMPLE_BITS-1]}}, q_op.sample};
      latest_next = q_op.sample;
      if (count == '0) begin
        least_next        = q_op.sample;
        greatest_next     = q_op.sample;
        mag_least_next    = q_op.mag;
        mag_greatest_next = q_op.mag;
      end else begin
        if (q_op.sample < least)    least_next        = q_op.sample;
        if (q_op.sample > greatest) greatest_next     = q_op.sample;
        if (q_op.mag < mag_least)   mag_least_next    = q_op.mag;
        if (q_op.mag > mag_greatest) mag_greatest_next = q_op.mag;
      end
    end
  end

  // divide the magnitude of the sum, then restore the sign (truncates toward zero)
  always_comb begin
    div_dividend = total[SUM_BITS-1] ? (~total + 1'b1) : total;
    avg_full     = total[SUM_BITS-1] ? (~div_quot + 1'b1) : div_quot;
    stats_next   = '0;
    stats_next.full_res = full_flag;
    if (count != '0) begin
      stats_next.sample_count       = count;
      stats_next.running_sum        = total;
      stats_next.last_sample        = latest;
      stats_next.least_value        = least;
      stats_next.greatest_value     = greatest;
      stats_next.least_magnitude    = mag_least[SAMPLE_BITS-1:0];
      stats_next.greatest_magnitude = mag_greatest[SAMPLE_BITS-1:0];
      stats_next.average            = avg_full[SAMPLE_BITS-1:0];
      stats_next.valid_res          = 1'b1;
    end
  end

  rss_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stats_valid  <= 1'b0;
      count        <= '0;
      total        <= '0;
      latest       <= '0;
      least        <= '0;
      greatest     <= '0;
      mag_least    <= '0;
      mag_greatest <= '0;
      full_flag    <= 1'b0;
    end else begin
      // a new result may load in the same cycle the old one leaves
      if (state == S_WRITE && out_free) begin
        stats_valid <= 1'b1;
      end else if (stats_valid && !stats_stall) begin
        stats_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            count        <= count_next;
            total        <= total_next;
            latest       <= latest_next;
            least        <= least_next;
            greatest     <= greatest_next;
            mag_least    <= mag_least_next;
            mag_greatest <= mag_greatest_next;
            full_flag    <= full_next;
            state        <= (count_next == '0) ? S_WRITE : S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            stats <= stats_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/running_sample_statistics.sv -----
// running_sample_statistics: top level; front queue plus statistics back end.
// Depends on rss_pkg, rss_front, rss_engine (and rss_divider below it).
//
//   channel   direction  handshake                payload
//   item      in         item_valid / item_stall  rss_pkg::item_t  (command, sample)
//   stats     out        stats_valid / stats_stall rss_pkg::stats_t (statistics, mean)
//
// Back end, per sample item: pop, divider launch, 40 divider steps at one
// quotient bit each, seeing the divider done, result write; an item that leaves
// the statistics empty goes from the pop straight to the result write.
// The 40-step mean divider sets the rate; no pop until the last result is written.
// Reset (rst, synchronous) clears the queue, all statistics and the result flag.
// The front queue keeps taking items while the back end divides or while a
// result sits stalled in the output register; item_stall rises only when full.
module running_sample_statistics #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  rss_pkg::item_t  item,
  output logic            stats_valid,
  input  logic            stats_stall,
  output rss_pkg::stats_t stats
);
  import rss_pkg::*;

  // queue head between front and back
  logic q_valid;
  logic q_pop;
  op_t  q_op;

  // front: classify clear vs add, precompute the sample magnitude, buffer items
  rss_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop)
  );

  // back: apply one item to the statistics, divide for the mean, register result
  rss_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_op        (q_op),
    .q_pop       (q_pop),
    .stats_valid (stats_valid),
    .stats_stall (stats_stall),
    .stats       (stats)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking testbench for running_sample_statistics (item in, stats out).
// Depends on rss_pkg and the block under test; a scoreboard class predicts every result.
module tb;
  import rss_pkg::*;

  localparam int TOTAL_ITEMS  = 1250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 100;   // margin after the last result before the verdict
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, queue fills meanwhile
  localparam int PRINT_CAP    = 40;

  // Scoreboard: private copy of the statistics state, one expected result per item.
  class stats_book;
    stats_t                        expected_q[$];
    int                            errors;
    logic [COUNT_BITS-1:0]         taken;
    longint                        total;
    logic signed [SAMPLE_BITS-1:0] latest;
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic [MAG_BITS-1:0]           mag_lo;
    logic [MAG_BITS-1:0]           mag_hi;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      taken  = '0;
      total  = 0;
      latest = '0;
      lo     = '0;
      hi     = '0;
      mag_lo = '0;
      mag_hi = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Update the state for one accepted item and queue the result it causes.
    function void note_item(item_t it);
      stats_t              r;
      logic                is_full;
      int                  sv;
      logic [MAG_BITS-1:0] m;
      longint              mean;
      is_full = 1'b0;
      r       = '0;
      if (it.command == CMD_CLEAR) begin
        wipe();
      end else if (taken == {COUNT_BITS{1'b1}}) begin
        is_full = 1'b1;      // count saturated: sample dropped, state kept
      end else begin
        sv     = it.sample;
        m      = (sv < 0) ? MAG_BITS'(-sv) : MAG_BITS'(sv);
        taken  = taken + 1'b1;
        total  = total + sv;
        latest = it.sample;
        if (taken == 1) begin
          lo     = it.sample;
          hi     = it.sample;
          mag_lo = m;
          mag_hi = m;
        end else begin
          if (it.sample < lo) lo = it.sample;
          if (it.sample > hi) hi = it.sample;
          if (m < mag_lo) mag_lo = m;
          if (m > mag_hi) mag_hi = m;
        end
      end
      if (taken != 0) begin
        mean                 = total / longint'(taken);   // truncates toward zero
        r.sample_count       = taken;
        r.running_sum        = total[SUM_BITS-1:0];
        r.last_sample        = latest;
        r.least_value        = lo;
        r.greatest_value     = hi;
        r.least_magnitude    = mag_lo[SAMPLE_BITS-1:0];
        r.greatest_magnitude = mag_hi[SAMPLE_BITS-1:0];
        r.average            = mean[SAMPLE_BITS-1:0];
        r.valid_res          = 1'b1;
      end
      r.full_res = is_full;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= PRINT_CAP)
        $display("[%0t] %s differs: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task check_result(stats_t got);
      stats_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing pending, count", got.sample_count, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.sample_count !== want.sample_count)
        report("sample_count", got.sample_count, want.sample_count);
      if (got.running_sum !== want.running_sum)
        report("running_sum", got.running_sum, want.running_sum);
      if (got.last_sample !== want.last_sample)
        report("last_sample", got.last_sample, want.last_sample);
      if (got.least_value !== want.least_value)
        report("least_value", got.least_value, want.least_value);
      if (got.greatest_value !== want.greatest_value)
        report("greatest_value", got.greatest_value, want.greatest_value);
      if (got.least_magnitude !== want.least_magnitude)
        report("least_magnitude", got.least_magnitude, want.least_magnitude);
      if (got.greatest_magnitude !== want.greatest_magnitude)
        report("greatest_magnitude", got.greatest_magnitude, want.greatest_magnitude);
      if (got.average !== want.average)
        report("average", got.average, want.average);
      if (got.valid_res !== want.valid_res)
        report("valid_res", got.valid_res, want.valid_res);
      if (got.full_res !== want.full_res)
        report("full_res", got.full_res, want.full_res);
    endtask
  endclass

  logic   clk          = 1'b0;
  logic   rst          = 1'b1;
  logic   item_valid   = 1'b0;
  logic   item_stall;
  item_t  item         = '0;
  logic   stats_valid;
  logic   stats_stall  = 1'b0;
  stats_t stats;

  int     tx_idle_pct  = 23;
  int     rx_idle_pct  = 23;
  logic   hold_request = 1'b0;
  int     items_sent   = 0;
  int     cycles       = 0;

  stats_book book = new();

  running_sample_statistics i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .stats_valid (stats_valid),
    .stats_stall (stats_stall),
    .stats       (stats)
  );

  always #5 clk = ~clk;

  // Run limit: the slowest legal run is about 1.3k items plus idle gaps and one
  // hold-off, far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("running_sample_statistics: mismatch");
      $finish;
    end
  end

  // Result side: an item is taken at a rising edge with valid high and stall low.
  always @(posedge clk) begin
    if (!rst && stats_valid && !stats_stall)
      book.check_result(stats);
  end

  // Receiver stall, driven at the falling edge. A hold request turns into a long
  // hold-off counted here, so the front queue fills and item_stall must rise.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stats_stall <= 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++)
          @(negedge clk);
      end
      stats_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offer one item from a falling edge, with random idle cycles first; returns
  // at the falling edge after it was taken.
  task automatic offer_item(input cmd_t c, input logic signed [SAMPLE_BITS-1:0] s);
    item_t it;
    it.command = c;
    it.sample  = s;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall)
      @(posedge clk);
    book.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Sample values by flavor: full range, extremes, near zero, one-signed runs.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int flavor);
    int v;
    case (flavor)
      1: begin
        case ($urandom_range(4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = -32767;
          default: v = int'($urandom_range(65535)) - 32768;
        endcase
      end
      2: v = int'($urandom_range(16)) - 8;
      3: v = int'($urandom_range(32767));
      4: v = -int'($urandom_range(32768));
      default: v = int'($urandom_range(65535)) - 32768;
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Wait at falling edges until every queued result has come out.
  task automatic drain_results();
    while (book.pending() != 0)
      @(negedge clk);
  endtask

  initial begin
    int burst;
    int flavor;
    int nburst;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty results, seeding by extremes, the most negative sample's
    // magnitude, truncation of a negative mean, clears that carry a junk sample.
    offer_item(CMD_CLEAR, 16'sh0000);
    offer_item(CMD_ADD,   16'sh0000);
    offer_item(CMD_ADD,   16'sh7FFF);
    offer_item(CMD_ADD,   -16'sd32768);
    offer_item(CMD_ADD,   -16'sd1);
    offer_item(CMD_ADD,   16'sd1);
    offer_item(CMD_CLEAR, 16'sh5A5A);
    offer_item(CMD_ADD,   -16'sd32768);
    offer_item(CMD_ADD,   16'sh7FFF);
    offer_item(CMD_ADD,   -16'sd32767);
    offer_item(CMD_CLEAR, -16'sd1);
    offer_item(CMD_CLEAR, 16'sh7FFF);
    offer_item(CMD_ADD,   16'sd1);
    offer_item(CMD_ADD,   -16'sd1);
    offer_item(CMD_ADD,   -16'sd2);
    offer_item(CMD_ADD,   -16'sd2);
    offer_item(CMD_ADD,   -16'sd3);
    offer_item(CMD_CLEAR, -16'sd32768);
    offer_item(CMD_ADD,   16'sh7FFF);
    offer_item(CMD_ADD,   16'sh7FFF);
    offer_item(CMD_ADD,   16'sh7FFE);
    offer_item(CMD_ADD,   16'sh0000);

    // Random: bursts of samples opened by a clear, so counts stay short and the
    // first-sample seeding is hit often; a few stray clears inside bursts.
    // Saturating the 24-bit count needs 16M samples and is out of reach here.
    nburst = 0;
    while (items_sent < TOTAL_ITEMS) begin
      nburst++;
      if (nburst == 4) begin
        hold_request = 1'b1;        // receiver stalls long, sender keeps going
      end
      if (nburst == 7) begin
        item_valid <= 1'b0;
        drain_results();            // sender pauses until the block is empty
      end
      if (nburst == 10) begin
        tx_idle_pct = 0;            // stretch with no idling on either side
        rx_idle_pct = 0;
      end
      if (nburst == 18) begin
        tx_idle_pct = 23;
        rx_idle_pct = 23;
      end
      burst  = ($urandom_range(15) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
      flavor = $urandom_range(4);
      offer_item(CMD_CLEAR, pick_sample(0));
      for (int k = 0; k < burst && items_sent < TOTAL_ITEMS; k++) begin
        if ($urandom_range(49) == 0)
          offer_item(CMD_CLEAR, pick_sample(0));
        else
          offer_item(CMD_ADD, pick_sample(($urandom_range(3) == 0) ? 0 : flavor));
      end
    end

    item_valid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (book.errors == 0)
      $display("running_sample_statistics: match");
    else
      $display("running_sample_statistics: mismatch");
    $finish;
  end

endmodule
